>>> hw/rtl/bfba_pkg.sv
// Shared constants of the best-fit block allocator: default sizes, status codes and phase codes.
// No dependencies.
package bfba_pkg;
    localparam int DEF_ADDR_BITS  = 16;
    localparam int DEF_MAX_BLOCKS = 16;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NOFIT   = 3'd1;
    localparam status_t ST_BADSIZE = 3'd2;
    localparam status_t ST_FULL    = 3'd3;
    localparam status_t ST_UNKNOWN = 3'd4;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_EDIT   = 2'd1;
    localparam logic [1:0] PH_FINISH = 2'd2;
endpackage

>>> hw/rtl/best_fit_block_allocator.sv
// Best-fit block allocator: top level with control, free ring and used ring.
// Depends on bfba_pkg, bfba_ring and bfba_cell.
//
// Input channel s_*: one request per transaction; s_tuser is the action
// (0 allocate, 1 free), s_tdata carries request_size and block_address.
// Output channel m_*: one result per request with status, address and pool
// statistics taken after the step.
// Each request runs as three full rotations of the free-block ring (search,
// edit, finish with statistics), the used ring turning along with it, and
// then loads the result register.
// Only one request is in progress at a time.
// A new request is taken once the rotations are done, also while the last
// result still waits; a stalled receiver holds the block after the next
// request's rotations until the result register is free.
// Reset makes the pool 2^ADDR_BITS bytes as one free block with no
// allocated blocks; a write on cfg_wr_en does the same with the written
// pool size (0 taken as 1, larger than 2^ADDR_BITS clamped).
module best_fit_block_allocator
    import bfba_pkg::*;
#(
    parameter int ADDR_BITS  = DEF_ADDR_BITS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    localparam int SW = ADDR_BITS + 1,
    localparam int IW = ((2 * ADDR_BITS + 1 + 7) / 8) * 8,
    localparam int OW = ((3 + ADDR_BITS + 4 * SW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [SW-1:0] cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [IW-1:0] s_tdata,  // request_size, block_address, zero pad
    input  logic          s_tuser,  // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [OW-1:0] m_tdata   // status, granted_address, free_bytes,
                                    // used_bytes, largest_free, smallest_free
);
    localparam int FD = MAX_BLOCKS + 1;
    localparam int EW = 1 + ADDR_BITS + SW;
    localparam int CW = $clog2(FD);
    localparam int UW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SW-1:0] POOL_MAX = SW'(1) << ADDR_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic act_reg;
    logic [SW-1:0] size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SW-1:0] flen_reg;

    logic best_reg, best_next;
    logic [ADDR_BITS-1:0] bs_reg, bs_next;
    logic [SW-1:0] bl_reg, bl_next;
    logic [UW-1:0] ucnt_reg, ucnt_next;
    logic found_reg, found_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic hp_reg, hp_next;
    logic [ADDR_BITS-1:0] ps_reg, ps_next;
    logic ins_reg, ins_next;
    status_t st_reg, st_next;
    logic [SW-1:0] fsum_reg, fsum_next, usum_reg, usum_next;
    logic [SW-1:0] big_reg, big_next, small_reg, small_next;
    logic sm_reg, sm_next;
    logic outv_reg;
    logic [OW-1:0] outd_reg;

    logic init;
    logic [SW-1:0] pool;
    logic [EW-1:0] f_head, f_feed, u_head, u_feed, f_init;
    logic f_shift, u_shift;
    logic fv, uv, fvo, uvo;
    logic [ADDR_BITS-1:0] fs, us, fso, uso;
    logic [SW-1:0] fl, ul, flo, ulo;
    logic running, last, out_free, ok;

    assign init = !aresetn || cfg_wr_en;

    always_comb begin
        pool = cfg_wr_data;
        if (!aresetn) begin
            pool = POOL_MAX;
        end else if (cfg_wr_data == '0) begin
            pool = SW'(1);
        end else if (cfg_wr_data > POOL_MAX) begin
            pool = POOL_MAX;
        end
    end

    assign f_init = {1'b1, {ADDR_BITS{1'b0}}, pool};
    assign {fv, fs, fl} = f_head;
    assign {uv, us, ul} = u_head;
    assign f_feed = {fvo, fso, flo};
    assign u_feed = {uvo, uso, ulo};

    assign running = (state_reg == S_RUN);
    assign last = (cnt_reg == CW'(FD - 1));
    assign f_shift = running;
    assign u_shift = running && (cnt_reg < CW'(MAX_BLOCKS));
    assign out_free = !outv_reg || m_tready;
    assign ok = (st_reg == ST_OK);

    bfba_ring #(.DEPTH(FD), .WIDTH(EW)) u_free_ring (
        .aclk       (aclk),
        .init       (init),
        .init_first (f_init),
        .shift      (f_shift),
        .feed       (f_feed),
        .head       (f_head)
    );

    bfba_ring #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_used_ring (
        .aclk       (aclk),
        .init       (init),
        .init_first ('0),
        .shift      (u_shift),
        .feed       (u_feed),
        .head       (u_head)
    );

    always_comb begin
        fvo = fv; fso = fs; flo = fl;
        uvo = uv; uso = us; ulo = ul;
        best_next = best_reg; bs_next = bs_reg; bl_next = bl_reg;
        ucnt_next = ucnt_reg; found_next = found_reg; acc_next = acc_reg;
        hp_next = hp_reg; ps_next = ps_reg; ins_next = ins_reg;
        st_next = st_reg;
        fsum_next = fsum_reg; usum_next = usum_reg;
        big_next = big_reg; small_next = small_reg; sm_next = sm_reg;
        unique case (phase_reg)
            PH_SEARCH: begin
                if (!act_reg) begin
                    if (fv && fl >= size_reg && (!best_reg || fl < bl_reg ||
                            (fl == bl_reg && fs < bs_reg))) begin
                        best_next = 1'b1; bs_next = fs; bl_next = fl;
                    end
                    if (u_shift && uv) begin
                        ucnt_next = ucnt_reg + UW'(1);
                    end
                end else if (u_shift && uv && !found_reg && us == addr_reg) begin
                    found_next = 1'b1;
                    acc_next = ul;
                    uvo = 1'b0;
                end
                if (last) begin
                    if (!act_reg) begin
                        if (size_reg == '0) begin
                            st_next = ST_BADSIZE;
                        end else if (!best_next) begin
                            st_next = ST_NOFIT;
                        end else if (ucnt_next >= UW'(MAX_BLOCKS)) begin
                            st_next = ST_FULL;
                        end else begin
                            st_next = ST_OK;
                        end
                    end else begin
                        st_next = found_next ? ST_OK : ST_UNKNOWN;
                    end
                end
            end
            PH_EDIT: begin
                if (ok && !act_reg) begin
                    if (fv && fs == bs_reg) begin
                        if (fl > size_reg) begin
                            fso = fs + size_reg[ADDR_BITS-1:0];
                            flo = fl - size_reg;
                        end else begin
                            fvo = 1'b0;
                        end
                    end
                    if (u_shift && !uv && !ins_reg) begin
                        uvo = 1'b1; uso = bs_reg; ulo = size_reg;
                        ins_next = 1'b1;
                    end
                end else if (ok && act_reg && fv) begin
                    if ((SW'(fs) + fl) == SW'(addr_reg)) begin
                        hp_next = 1'b1; ps_next = fs;
                        acc_next = acc_reg + fl;
                        fvo = 1'b0;
                    end else if (SW'(fs) == SW'(addr_reg) + flen_reg) begin
                        acc_next = acc_reg + fl;
                        fvo = 1'b0;
                    end
                end
            end
            PH_FINISH: begin
                if (ok && act_reg && !fv && !ins_reg) begin
                    fvo = 1'b1; fso = hp_reg ? ps_reg : addr_reg; flo = acc_reg;
                    ins_next = 1'b1;
                end
                if (fvo) begin
                    fsum_next = fsum_reg + flo;
                    if (flo > big_reg) begin
                        big_next = flo;
                    end
                    if (!sm_reg || flo < small_reg) begin
                        small_next = flo;
                    end
                    sm_next = 1'b1;
                end
                if (u_shift && uv) begin
                    usum_next = usum_reg + ul;
                end
            end
            default: begin
                fvo = fv;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (running && phase_reg == PH_SEARCH && act_reg && u_shift && uv
                && !found_reg && us == addr_reg) begin
            flen_reg <= ul;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_RUN;
                    phase_next = PH_SEARCH;
                    cnt_next = '0;
                end
            end
            S_RUN: begin
                if (last) begin
                    cnt_next = '0;
                    if (phase_reg == PH_FINISH) begin
                        state_next = S_HOLD;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_SEARCH;
            cnt_reg <= '0;
            outv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            if (state_reg == S_HOLD && out_free) begin
                outv_reg <= 1'b1;
            end else if (m_tready) begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= s_tuser;
            size_reg <= s_tdata[SW-1:0];
            addr_reg <= s_tdata[SW+ADDR_BITS-1:SW];
            best_reg <= 1'b0; bs_reg <= '0; bl_reg <= '0;
            ucnt_reg <= '0; found_reg <= 1'b0; acc_reg <= '0;
            hp_reg <= 1'b0; ps_reg <= '0; ins_reg <= 1'b0;
            st_reg <= ST_OK;
            fsum_reg <= '0; usum_reg <= '0; big_reg <= '0;
            small_reg <= '0; sm_reg <= 1'b0;
        end else if (running) begin
            best_reg <= best_next; bs_reg <= bs_next; bl_reg <= bl_next;
            ucnt_reg <= ucnt_next; found_reg <= found_next; acc_reg <= acc_next;
            hp_reg <= hp_next; ps_reg <= ps_next;
            ins_reg <= (last && phase_reg == PH_EDIT) ? 1'b0 : ins_next;
            st_reg <= st_next;
            fsum_reg <= fsum_next; usum_reg <= usum_next;
            big_reg <= big_next; small_reg <= small_next; sm_reg <= sm_next;
        end
        if (state_reg == S_HOLD && out_free) begin
            outd_reg <= OW'({small_reg, big_reg, usum_reg, fsum_reg,
                             ok ? (act_reg ? addr_reg : bs_reg) : {ADDR_BITS{1'b0}},
                             st_reg});
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata = outd_reg;
endmodule

>>> hw/rtl/bfba_cell.sv
// One table cell of the allocator ring: holds one entry and takes its neighbor's.
// Imports bfba_pkg but uses none of it; the entry width comes from the WIDTH parameter.
module bfba_cell
    import bfba_pkg::*;
#(
    parameter int WIDTH = 34
) (
    input  logic             aclk,
    input  logic             init,
    input  logic [WIDTH-1:0] init_val,
    input  logic             shift,
    input  logic [WIDTH-1:0] nbr,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (init) begin
            q_reg <= init_val;
        end else if (shift) begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;
endmodule

>>> hw/rtl/bfba_ring.sv
// Ring of bfba_cell entries; cell 0 is the head, the last cell takes the feed.
// Depends on bfba_cell; imports bfba_pkg but uses none of it.
module bfba_ring
    import bfba_pkg::*;
#(
    parameter int DEPTH = 17,
    parameter int WIDTH = 34
) (
    input  logic             aclk,
    input  logic             init,
    input  logic [WIDTH-1:0] init_first,
    input  logic             shift,
    input  logic [WIDTH-1:0] feed,
    output logic [WIDTH-1:0] head
);
    logic [WIDTH-1:0] q [DEPTH];
    logic [WIDTH-1:0] nbr [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            if (i == DEPTH - 1) begin : g_last
                assign nbr[i] = feed;
            end else begin : g_mid
                assign nbr[i] = q[i+1];
            end
            bfba_cell #(.WIDTH(WIDTH)) u_cell (
                .aclk     (aclk),
                .init     (init),
                .init_val ((i == 0) ? init_first : '0),
                .shift    (shift),
                .nbr      (nbr[i]),
                .q        (q[i])
            );
        end
    endgenerate

    assign head = q[0];
endmodule
